>>> rtl/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg: disk quota enforcer shared definitions
// Counter width, configuration register indexes, action and notice codes.
// ----------------------------------------------------------------------------
`default_nettype none

package dqe_pkg;

  localparam int COUNT_WIDTH = 32;
  // compare width: room for a counter or a 32-bit field plus one carry bit
  localparam int CMP_WIDTH   = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1;
  localparam int CFG_IDX_W   = 3;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [CMP_WIDTH-1:0]   cmp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUOTA_ENABLED    = 3'd0,
    CFG_BLOCK_SOFT_LIMIT = 3'd1,
    CFG_BLOCK_HARD_LIMIT = 3'd2,
    CFG_FILE_SOFT_LIMIT  = 3'd3,
    CFG_FILE_HARD_LIMIT  = 3'd4,
    CFG_BLOCK_GRACE      = 3'd5,
    CFG_FILE_GRACE       = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_BLOCK_CHANGE = 2'd0,
    ACT_FILE_CREATE  = 2'd1,
    ACT_FILE_DELETE  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    NOTE_NONE       = 3'd0,
    NOTE_BLOCK_HARD = 3'd1,
    NOTE_BLOCK_WARN = 3'd2,
    NOTE_BLOCK_OVER = 3'd3,
    NOTE_FILE_HARD  = 3'd4,
    NOTE_FILE_WARN  = 3'd5,
    NOTE_FILE_OVER  = 3'd6
  } notice_t;

  localparam cmp_t CNT_MAX = {{(CMP_WIDTH-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

  function automatic cmp_t ext_cnt(input cnt_t v);
    return {{(CMP_WIDTH-COUNT_WIDTH){1'b0}}, v};
  endfunction

  function automatic cmp_t ext_32(input logic [31:0] v);
    return {{(CMP_WIDTH-32){1'b0}}, v};
  endfunction

  // low 32 bits of a counter, zero extended when the counter is narrower
  function automatic logic [31:0] cnt_to_32(input cnt_t v);
    cmp_t w;
    w = ext_cnt(v);
    return w[31:0];
  endfunction

  // saturating counter add
  function automatic cnt_t sat_add(input cnt_t a, input logic [31:0] b);
    cmp_t s;
    s = ext_cnt(a) + ext_32(b);
    if (s > CNT_MAX) begin
      return {COUNT_WIDTH{1'b1}};
    end
    return s[COUNT_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/dqe_if.sv
// ----------------------------------------------------------------------------
// dqe_in_if / dqe_out_if: request and result channels
// Valid/ready channels carrying one quota request or one quota result.
// ----------------------------------------------------------------------------
`default_nettype none

interface dqe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic signed [31:0] block_change;
  logic        force_req;
  logic        is_superuser;
  logic        requester_is_owner;
  logic [31:0] now;

  modport source (output valid, action, block_change, force_req, is_superuser,
                  requester_is_owner, now, input ready);
  modport sink   (input valid, action, block_change, force_req, is_superuser,
                  requester_is_owner, now, output ready);
endinterface

interface dqe_out_if;
  logic        valid;
  logic        ready;
  logic        denied;
  logic [2:0]  notice;
  logic [31:0] block_usage_out;
  logic [31:0] file_usage_out;
  logic        record_modified;

  modport source (output valid, denied, notice, block_usage_out, file_usage_out,
                  record_modified, input ready);
  modport sink   (input valid, denied, notice, block_usage_out, file_usage_out,
                  record_modified, output ready);
endinterface

`default_nettype wire

>>> rtl/disk_quota_enforcer.sv
// ----------------------------------------------------------------------------
// disk_quota_enforcer: soft/hard quota with grace period, one record
// Updates block and file usage per request and refuses over-quota allocations.
// ----------------------------------------------------------------------------
// usage:
//   in_req   valid/ready request channel: action, block delta, force,
//            superuser, owner and current time
//   out_rsp  valid/ready result channel: denied, notice code, block and
//            file usage after the request, dirty mark
//   cfg_*    write-only register port, written only while the block is idle;
//            the user must keep to this, the block itself does not enforce it
// latency: the result is on out_rsp the cycle after acceptance; throughput:
//   one request per cycle; the whole quota update is one combinational pass
//   from record registers and request fields into record and result registers
// in_req.ready is high whenever the result register is empty or is being
//   taken in the same cycle, so a stalled receiver holds back one result
//   and then the request side
// reset (rst_n low, synchronous): registers, usage counters, deadlines,
//   warned flags and dirty mark go to zero, result register empties
// ----------------------------------------------------------------------------
`default_nettype none

module disk_quota_enforcer (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire [dqe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]                 cfg_wdata,
  dqe_in_if.sink                     in_req,
  dqe_out_if.source                  out_rsp
);
  import dqe_pkg::*;

  // configuration
  logic        quota_enabled_r;
  logic [31:0] block_soft_r, block_hard_r, file_soft_r, file_hard_r;
  logic [31:0] block_grace_r, file_grace_r;

  // quota record
  cnt_t        block_usage_r, block_usage_nxt;
  cnt_t        file_usage_r, file_usage_nxt;
  logic [31:0] block_deadline_r, block_deadline_nxt;
  logic [31:0] file_deadline_r, file_deadline_nxt;
  logic        block_warned_r, block_warned_nxt;
  logic        file_warned_r, file_warned_nxt;
  logic        dirty_r, dirty_nxt;

  // result register
  logic        out_valid_r;
  logic        denied_r, denied_nxt;
  notice_t     notice_r, notice_nxt;

  logic        accept;
  logic        active;
  logic [31:0] raw, mag;
  cnt_t        ncur, bfree;
  cmp_t        sub_w;

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;
  assign active       = quota_enabled_r &&
                        ((block_soft_r | block_hard_r | file_soft_r | file_hard_r) != '0);

  assign raw   = in_req.block_change;
  assign mag   = ~raw + 32'd1;
  assign sub_w = ext_cnt(block_usage_r) - ext_32(mag);
  assign bfree = (ext_cnt(block_usage_r) >= ext_32(mag)) ? sub_w[COUNT_WIDTH-1:0] : '0;

  always_comb begin
    block_usage_nxt    = block_usage_r;
    file_usage_nxt     = file_usage_r;
    block_deadline_nxt = block_deadline_r;
    file_deadline_nxt  = file_deadline_r;
    block_warned_nxt   = block_warned_r;
    file_warned_nxt    = file_warned_r;
    dirty_nxt          = dirty_r;
    denied_nxt         = 1'b0;
    notice_nxt         = NOTE_NONE;
    ncur               = '0;

    case (in_req.action)
      ACT_BLOCK_CHANGE: begin
        if (active && raw != '0) begin
          dirty_nxt = 1'b1;
          if (raw[31]) begin
            // free: floor at zero
            block_usage_nxt  = bfree;
            block_warned_nxt = 1'b0;
            if (ext_cnt(bfree) < ext_32(block_soft_r)) begin
              block_deadline_nxt = '0;
            end
          end else begin
            ncur = sat_add(block_usage_r, raw);
            if (!in_req.is_superuser) begin
              if (block_hard_r != '0 && ext_cnt(ncur) >= ext_32(block_hard_r) &&
                  !in_req.force_req) begin
                if (!block_warned_nxt && in_req.requester_is_owner) begin
                  notice_nxt       = NOTE_BLOCK_HARD;
                  block_warned_nxt = 1'b1;
                end
                denied_nxt = 1'b1;
              end
              if (block_soft_r != '0 && ext_cnt(ncur) >= ext_32(block_soft_r)) begin
                if (ext_cnt(block_usage_r) < ext_32(block_soft_r) ||
                    block_deadline_r == '0) begin
                  block_deadline_nxt = in_req.now + block_grace_r;
                  if (in_req.requester_is_owner && notice_nxt == NOTE_NONE) begin
                    notice_nxt = NOTE_BLOCK_WARN;
                  end
                end else if (in_req.now > block_deadline_r && !in_req.force_req) begin
                  if (!block_warned_nxt && in_req.requester_is_owner) begin
                    notice_nxt       = NOTE_BLOCK_OVER;
                    block_warned_nxt = 1'b1;
                  end
                  denied_nxt = 1'b1;
                end
              end
            end
            if (!denied_nxt) begin
              block_usage_nxt = ncur;
            end
          end
        end
      end
      ACT_FILE_CREATE: begin
        if (quota_enabled_r && (file_soft_r | file_hard_r) != '0) begin
          dirty_nxt = 1'b1;
          ncur      = sat_add(file_usage_r, 32'd1);
          if (!in_req.is_superuser) begin
            if (file_hard_r != '0 && ext_cnt(ncur) >= ext_32(file_hard_r) &&
                !in_req.force_req) begin
              if (!file_warned_r && in_req.requester_is_owner) begin
                notice_nxt      = NOTE_FILE_HARD;
                file_warned_nxt = 1'b1;
              end
              denied_nxt = 1'b1;
            end else if (file_soft_r != '0 && ext_cnt(ncur) >= ext_32(file_soft_r)) begin
              if (ext_cnt(ncur) == ext_32(file_soft_r) || file_deadline_r == '0) begin
                file_deadline_nxt = in_req.now + file_grace_r;
                if (in_req.requester_is_owner) begin
                  notice_nxt = NOTE_FILE_WARN;
                end
              end else if (in_req.now > file_deadline_r && !in_req.force_req) begin
                if (!file_warned_r && in_req.requester_is_owner) begin
                  notice_nxt      = NOTE_FILE_OVER;
                  file_warned_nxt = 1'b1;
                end
                denied_nxt = 1'b1;
              end
            end
          end
          if (!denied_nxt) begin
            file_usage_nxt = ncur;
          end
        end
      end
      ACT_FILE_DELETE: begin
        if (active) begin
          dirty_nxt       = 1'b1;
          file_warned_nxt = 1'b0;
          if (file_usage_r != '0) begin
            file_usage_nxt = file_usage_r - cnt_t'(1);
          end
          if (ext_cnt(file_usage_nxt) < ext_32(file_soft_r)) begin
            file_deadline_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quota_enabled_r <= 1'b0;
      block_soft_r    <= '0;
      block_hard_r    <= '0;
      file_soft_r     <= '0;
      file_hard_r     <= '0;
      block_grace_r   <= '0;
      file_grace_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUOTA_ENABLED:    quota_enabled_r <= cfg_wdata[0];
        CFG_BLOCK_SOFT_LIMIT: block_soft_r    <= cfg_wdata;
        CFG_BLOCK_HARD_LIMIT: block_hard_r    <= cfg_wdata;
        CFG_FILE_SOFT_LIMIT:  file_soft_r     <= cfg_wdata;
        CFG_FILE_HARD_LIMIT:  file_hard_r     <= cfg_wdata;
        CFG_BLOCK_GRACE:      block_grace_r   <= cfg_wdata;
        CFG_FILE_GRACE:       file_grace_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // quota record and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_usage_r    <= '0;
      file_usage_r     <= '0;
      block_deadline_r <= '0;
      file_deadline_r  <= '0;
      block_warned_r   <= 1'b0;
      file_warned_r    <= 1'b0;
      dirty_r          <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (accept) begin
        block_usage_r    <= block_usage_nxt;
        file_usage_r     <= file_usage_nxt;
        block_deadline_r <= block_deadline_nxt;
        file_deadline_r  <= file_deadline_nxt;
        block_warned_r   <= block_warned_nxt;
        file_warned_r    <= file_warned_nxt;
        dirty_r          <= dirty_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, usage outputs come straight from the record
  always_ff @(posedge clk) begin
    if (accept) begin
      denied_r <= denied_nxt;
      notice_r <= notice_nxt;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.denied          = denied_r;
  assign out_rsp.notice          = notice_r;
  assign out_rsp.block_usage_out = cnt_to_32(block_usage_r);
  assign out_rsp.file_usage_out  = cnt_to_32(file_usage_r);
  assign out_rsp.record_modified = dirty_r;

endmodule

`default_nettype wire

>>> rtl/dqe_checker.sv
// ----------------------------------------------------------------------------
// dqe_checker: port-level checks for the disk quota enforcer
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dqe_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       out_denied,
  input wire [2:0] out_notice,
  input wire       out_modified
);
  import dqe_pkg::*;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every accepted request shows a result the next cycle
  a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted request produced no result");

  // a pending result holds until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  // the file soft warning never comes with a refusal
  a_warn_not_denied: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_notice == NOTE_FILE_WARN) |-> !out_denied)
    else $error("file warning with denied");

  // the dirty mark never falls back between consecutive results
  a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_modified && in_acc) |=> out_modified)
    else $error("dirty mark cleared");

endmodule

bind disk_quota_enforcer dqe_checker u_dqe_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .out_denied   (out_rsp.denied),
  .out_notice   (out_rsp.notice),
  .out_modified (out_rsp.record_modified)
);

`default_nettype wire

>>> bench/disk_quota_enforcer_tb.sv
// ----------------------------------------------------------------------------
// disk_quota_enforcer_tb: self-checking bench for the quota enforcer
// Drives quota requests through the valid/ready channels under several limit
// settings and compares each result with a cycle-free quota predictor.
// ----------------------------------------------------------------------------
module disk_quota_enforcer_tb;
  import dqe_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] delta;
    logic        frc;
    logic        su;
    logic        owner;
    logic [31:0] stamp;
  } quota_req_t;

  typedef struct packed {
    logic        denied;
    notice_t     notice;
    logic [31:0] blocks;
    logic [31:0] files;
    logic        modified;
  } quota_rsp_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  dqe_in_if  req_if ();
  dqe_out_if rsp_if ();

  disk_quota_enforcer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (req_if),
    .out_rsp   (rsp_if)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers and the quota record
  logic        q_en = 1'b0;
  logic [31:0] b_soft = '0, b_hard = '0, f_soft = '0, f_hard = '0;
  logic [31:0] b_grace = '0, f_grace = '0;
  cnt_t        blk_use = '0, file_use = '0;
  logic [31:0] blk_dl = '0, file_dl = '0;
  logic        blk_warn = 1'b0, file_warn = 1'b0, dirty = 1'b0;

  quota_rsp_t  pending_results [$];
  quota_rsp_t  want_rsp;
  logic        no_idle = 1'b0;
  logic [31:0] clock_s;
  int          errors = 0;
  int          n_checked = 0;
  int          n_refused = 0;
  int          n_settings = 0;
  logic [6:0]  notice_seen = '0;
  int          quiet_cycles = 0;

  function automatic quota_rsp_t apply_quota(input quota_req_t r);
    quota_rsp_t  res;
    logic [31:0] mag;
    cnt_t        nxt;
    logic        live;
    res = '0;
    live = q_en && ((b_soft | b_hard | f_soft | f_hard) != 0);
    if (r.act == ACT_BLOCK_CHANGE && live && r.delta != 0) begin
      dirty = 1'b1;
      if (r.delta[31]) begin
        mag = ~r.delta + 32'd1;
        blk_use = (ext_cnt(blk_use) >= ext_32(mag)) ? cnt_t'(blk_use - mag) : '0;
        if (blk_use < b_soft) blk_dl = '0;
        blk_warn = 1'b0;
      end else begin
        nxt = sat_add(blk_use, r.delta);
        if (!r.su) begin
          if (b_hard != 0 && nxt >= b_hard && !r.frc) begin
            if (!blk_warn && r.owner) begin
              res.notice = NOTE_BLOCK_HARD;
              blk_warn = 1'b1;
            end
            res.denied = 1'b1;
          end
          // soft check runs even after a hard refusal, deadline may still start
          if (b_soft != 0 && nxt >= b_soft) begin
            if (blk_use < b_soft || blk_dl == 0) begin
              blk_dl = r.stamp + b_grace;
              if (r.owner && res.notice == NOTE_NONE) res.notice = NOTE_BLOCK_WARN;
            end else if (r.stamp > blk_dl && !r.frc) begin
              if (!blk_warn && r.owner) begin
                res.notice = NOTE_BLOCK_OVER;
                blk_warn = 1'b1;
              end
              res.denied = 1'b1;
            end
          end
        end
        if (!res.denied) blk_use = nxt;
      end
    end else if (r.act == ACT_FILE_CREATE && q_en && (f_soft != 0 || f_hard != 0)) begin
      dirty = 1'b1;
      nxt = sat_add(file_use, 32'd1);
      if (!r.su) begin
        if (f_hard != 0 && nxt >= f_hard && !r.frc) begin
          if (!file_warn && r.owner) begin
            res.notice = NOTE_FILE_HARD;
            file_warn = 1'b1;
          end
          res.denied = 1'b1;
        end else if (f_soft != 0 && nxt >= f_soft) begin
          if (nxt == f_soft || file_dl == 0) begin
            file_dl = r.stamp + f_grace;
            if (r.owner) res.notice = NOTE_FILE_WARN;
          end else if (r.stamp > file_dl && !r.frc) begin
            if (!file_warn && r.owner) begin
              res.notice = NOTE_FILE_OVER;
              file_warn = 1'b1;
            end
            res.denied = 1'b1;
          end
        end
      end
      if (!res.denied) file_use = nxt;
    end else if (r.act == ACT_FILE_DELETE && live) begin
      dirty = 1'b1;
      if (file_use != 0) file_use = file_use - cnt_t'(1);
      if (file_use < f_soft) file_dl = '0;
      file_warn = 1'b0;
    end
    res.blocks   = cnt_to_32(blk_use);
    res.files    = cnt_to_32(file_use);
    res.modified = dirty;
    return res;
  endfunction

  function automatic quota_req_t quota_req(input logic [1:0] act, input logic [31:0] delta,
                                           input logic frc, input logic su, input logic owner,
                                           input logic [31:0] stamp);
    quota_req_t r;
    r.act   = act;
    r.delta = delta;
    r.frc   = frc;
    r.su    = su;
    r.owner = owner;
    r.stamp = stamp;
    return r;
  endfunction

  function automatic quota_req_t random_req(input logic [31:0] span, input logic [31:0] step);
    quota_req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) r.act = ACT_BLOCK_CHANGE;
    else if (pick < 75) r.act = ACT_FILE_CREATE;
    else if (pick < 95) r.act = ACT_FILE_DELETE;
    else r.act = ACT_UNUSED;
    case ($urandom_range(9))
      0: r.delta = $urandom();
      1: r.delta = '0;
      2, 3, 4: r.delta = -$urandom_range(span, 1);
      default: r.delta = $urandom_range(span, 1);
    endcase
    r.frc   = ($urandom_range(9) == 0);
    r.su    = ($urandom_range(9) == 0);
    r.owner = ($urandom_range(9) < 7);
    if ($urandom_range(9) == 0) begin
      r.stamp = $urandom();
    end else begin
      clock_s = clock_s + $urandom_range(step);
      r.stamp = clock_s;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("ERROR @%0t %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic send_req(input quota_req_t r);
    while (!no_idle && $urandom_range(99) < 11) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid              <= 1'b1;
    req_if.action             <= r.act;
    req_if.block_change       <= r.delta;
    req_if.force_req          <= r.frc;
    req_if.is_superuser       <= r.su;
    req_if.requester_is_owner <= r.owner;
    req_if.now                <= r.stamp;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(apply_quota(r));
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_quota(input logic en, input logic [31:0] bs, input logic [31:0] bh,
                               input logic [31:0] fs, input logic [31:0] fh,
                               input logic [31:0] bg, input logic [31:0] fg);
    cfg_idx_t    order [7];
    logic [31:0] vals [7];
    int          i;
    order = '{CFG_QUOTA_ENABLED, CFG_BLOCK_SOFT_LIMIT, CFG_BLOCK_HARD_LIMIT,
              CFG_FILE_SOFT_LIMIT, CFG_FILE_HARD_LIMIT, CFG_BLOCK_GRACE, CFG_FILE_GRACE};
    vals  = '{{31'd0, en}, bs, bh, fs, fh, bg, fg};
    for (i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    q_en    = en;
    b_soft  = bs;
    b_hard  = bh;
    f_soft  = fs;
    f_hard  = fh;
    b_grace = bg;
    f_grace = fg;
    n_settings++;
  endtask

  task automatic run_random_phase(input int n, input logic [31:0] span,
                                  input logic [31:0] step, input int pause_at);
    int k;
    for (k = 0; k < n; k++) begin
      if (k == pause_at) wait_all_results();
      send_req(random_req(span, step));
    end
    wait_all_results();
  endtask

  // disabled filesystem and enabled with no limits: nothing is counted
  task automatic test_inactive_record();
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd5, 1'b0, 1'b0, 1'b1, 32'd0));
    send_req(quota_req(ACT_FILE_CREATE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0));
    send_req(quota_req(ACT_FILE_DELETE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0));
    wait_all_results();
    program_quota(1'b1, 0, 0, 0, 0, 0, 0);
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd5, 1'b0, 1'b0, 1'b1, 32'd0));
    send_req(quota_req(ACT_FILE_DELETE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0));
    send_req(quota_req(ACT_FILE_CREATE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0));
    wait_all_results();
  endtask

  task automatic test_block_limits();
    program_quota(1'b1, 32'd10, 32'd20, 0, 0, 32'd100, 0);
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd5, 1'b0, 1'b0, 1'b1, 32'd1000));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd1000));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd5, 1'b0, 1'b0, 1'b1, 32'd1000));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd3, 1'b0, 1'b0, 1'b1, 32'd1050));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd3, 1'b0, 1'b0, 1'b1, 32'd1200));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd3, 1'b1, 1'b0, 1'b1, 32'd1201));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd4, 1'b0, 1'b0, 1'b1, 32'd1202));
    send_req(quota_req(ACT_BLOCK_CHANGE, -32'sd20, 1'b0, 1'b0, 1'b1, 32'd1300));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd6, 1'b0, 1'b0, 1'b1, 32'd2000));
    // hard limit and a fresh soft deadline from one allocation
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd14, 1'b0, 1'b0, 1'b1, 32'd2000));
    send_req(quota_req(ACT_BLOCK_CHANGE, -32'sd6, 1'b0, 1'b0, 1'b1, 32'd2001));
    wait_all_results();
    // deadline sum wraps, then usage saturates at the counter maximum
    program_quota(1'b1, 32'd5, 0, 32'd1, 0, 32'h200, 0);
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'hFFFF_FF00));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'hFFFF_FF80));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, 32'hFFFF_FF90));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'd1, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'h8000_0000, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'h8000_0000, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF));
    wait_all_results();
  endtask

  task automatic test_file_limits();
    program_quota(1'b1, 0, 0, 32'd2, 32'd4, 0, 32'd50);
    send_req(quota_req(ACT_FILE_DELETE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd0));
    send_req(quota_req(ACT_FILE_CREATE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd10));
    send_req(quota_req(ACT_FILE_CREATE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd10));
    send_req(quota_req(ACT_FILE_CREATE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd70));
    send_req(quota_req(ACT_FILE_CREATE, 32'd0, 1'b1, 1'b0, 1'b1, 32'd71));
    send_req(quota_req(ACT_FILE_CREATE, 32'd0, 1'b1, 1'b0, 1'b1, 32'd72));
    send_req(quota_req(ACT_FILE_CREATE, 32'd0, 1'b0, 1'b1, 1'b1, 32'd73));
    send_req(quota_req(ACT_FILE_DELETE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd74));
    send_req(quota_req(ACT_FILE_CREATE, 32'd0, 1'b0, 1'b0, 1'b1, 32'd75));
    send_req(quota_req(ACT_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'd76));
    wait_all_results();
  endtask

  task automatic test_random_settings();
    logic [31:0] bs, fs;
    bs = $urandom_range(60, 10);
    fs = $urandom_range(8, 1);
    program_quota(1'b1, bs, bs + $urandom_range(60, 1), fs, fs + $urandom_range(8, 1),
                  $urandom_range(30), $urandom_range(30));
    run_random_phase(100, 32'd40, 32'd4, 50);
    // soft limits only, zero grace
    program_quota(1'b1, $urandom_range(60, 10), 0, $urandom_range(8, 1), 0, 0, 0);
    run_random_phase(95, 32'd30, 32'd3, -1);
    // hard limits only
    program_quota(1'b1, 0, $urandom_range(80, 20), 0, $urandom_range(10, 2), 32'd5, 32'd5);
    run_random_phase(95, 32'd30, 32'd3, -1);
    // every register at its maximum, full-range deltas, back-to-back traffic
    no_idle = 1'b1;
    program_quota(1'b1, '1, '1, '1, '1, '1, '1);
    run_random_phase(95, 32'hFFFF_FFFF, 32'h0001_0000, -1);
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'h8000_0000, 1'b0, 1'b0, 1'b1, clock_s));
    send_req(quota_req(ACT_BLOCK_CHANGE, 32'h8000_0000, 1'b0, 1'b0, 1'b1, clock_s));
    wait_all_results();
    no_idle = 1'b0;
    program_quota(1'b0, 32'd20, 32'd40, 32'd3, 32'd6, 32'd10, 32'd10);
    run_random_phase(40, 32'd30, 32'd2, -1);
    // block limits only: creates are ignored, deletes still count
    program_quota(1'b1, 32'd25, 32'd50, 0, 0, 32'd8, 0);
    run_random_phase(95, 32'd30, 32'd3, -1);
    program_quota(1'b1, 0, 0, 32'd4, 32'd8, 0, 32'd8);
    run_random_phase(95, 32'd30, 32'd3, -1);
    // hard limit below soft limit
    program_quota(1'b1, 32'd40, 32'd20, 32'd6, 32'd3, 32'd12, 32'd12);
    run_random_phase(95, 32'd30, 32'd3, -1);
    // huge grace so deadlines wrap past zero
    program_quota(1'b1, 32'd30, 32'd60, 32'd5, 32'd10, 32'hFFFF_FFF0, 32'hFFFF_FF00);
    run_random_phase(95, 32'd30, 32'h4000_0000, -1);
  endtask

  always @(posedge clk) begin
    rsp_if.ready <= no_idle || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", rsp_if.block_usage_out, '0);
      end else begin
        want_rsp = pending_results.pop_front();
        n_checked++;
        if (rsp_if.denied) n_refused++;
        if (rsp_if.notice <= NOTE_FILE_OVER) notice_seen[rsp_if.notice] = 1'b1;
        if (rsp_if.denied !== want_rsp.denied)
          report_mismatch("denied", rsp_if.denied, want_rsp.denied);
        if (rsp_if.notice !== want_rsp.notice)
          report_mismatch("notice", rsp_if.notice, want_rsp.notice);
        if (rsp_if.block_usage_out !== want_rsp.blocks)
          report_mismatch("block usage", rsp_if.block_usage_out, want_rsp.blocks);
        if (rsp_if.file_usage_out !== want_rsp.files)
          report_mismatch("file usage", rsp_if.file_usage_out, want_rsp.files);
        if (rsp_if.record_modified !== want_rsp.modified)
          report_mismatch("record modified", rsp_if.record_modified, want_rsp.modified);
      end
    end
  end

  // stall detector: nothing moving on either channel for too long
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_index                 = CFG_QUOTA_ENABLED;
    cfg_wdata                 = '0;
    req_if.valid              = 1'b0;
    req_if.action             = ACT_BLOCK_CHANGE;
    req_if.block_change       = '0;
    req_if.force_req          = 1'b0;
    req_if.is_superuser       = 1'b0;
    req_if.requester_is_owner = 1'b0;
    req_if.now                = '0;
    rsp_if.ready              = 1'b0;
    clock_s                   = $urandom_range(1000);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_inactive_record();
    test_block_limits();
    test_file_limits();
    test_random_settings();
    wait_all_results();
    repeat (4) @(posedge clk);
    $display("checked %0d results over %0d register settings, %0d requests refused",
             n_checked, n_settings, n_refused);
    $display("notice codes observed, one bit per code from none upward: %b", notice_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
